[rtl/itli_pkg.sv]
// shared constants for the piecewise linear interpolation table
`default_nettype none
package itli_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned ProdW = 2 * DataW;
  localparam int unsigned CountW = 5;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;
endpackage
`default_nettype wire

[rtl/itli_search.sv]
// breakpoint search: parallel compares and a priority pick of the bracketing pair
`default_nettype none
module itli_search import itli_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16,
  parameter int unsigned IW = 4
) (
  input  wire logic [DataW-1:0] times_i [MAX_POINTS],
  input  wire logic [DataW-1:0] query_i,
  input  wire logic [IW-1:0]    last_i,
  output logic      [IW-1:0]    lo_o,
  output logic      [IW-1:0]    hi_o
);
  logic [MAX_POINTS-1:0] hit;
  logic [IW-1:0]         i2;
  logic                  below_first;
  logic                  past_last;

  always_comb begin
    hit = '0;
    for (int i = 1; i < MAX_POINTS; i++) begin
      hit[i] = (IW'(i) < last_i) && ($signed(times_i[i]) > $signed(query_i));
    end
    i2 = last_i;
    for (int i = MAX_POINTS - 1; i >= 1; i--) begin
      if (hit[i]) begin
        i2 = IW'(i);
      end
    end
    below_first = $signed(query_i) < $signed(times_i[0]);
    past_last   = $signed(query_i) >= $signed(times_i[last_i]);
    priority if (below_first) begin
      lo_o = '0;
      hi_o = '0;
    end else if (past_last) begin
      lo_o = last_i;
      hi_o = last_i;
    end else begin
      lo_o = i2 - IW'(1);
      hi_o = i2;
    end
  end
endmodule
`default_nettype wire

[rtl/itli_div.sv]
// pipelined restoring divider, one quotient bit per stage, with signed offset add
`default_nettype none
module itli_div import itli_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [ProdW-1:0] dividend_i,
  input  wire logic [DataW-1:0] den_i,
  input  wire logic [DataW-1:0] base_i,
  input  wire logic             neg_i,
  output logic      [DataW-1:0] result_o
);
  localparam int unsigned Steps = DataW;

  logic [DataW-1:0] rem_q  [Steps+1];
  logic [DataW-1:0] low_q  [Steps+1];
  logic [DataW-1:0] den_q  [Steps+1];
  logic [DataW-1:0] base_q [Steps+1];
  logic             neg_q  [Steps+1];

  always_comb begin
    rem_q[0]  = dividend_i[ProdW-1:DataW];
    low_q[0]  = dividend_i[DataW-1:0];
    den_q[0]  = den_i;
    base_q[0] = base_i;
    neg_q[0]  = neg_i;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [DataW:0]   trial;
    logic             ge;
    logic [DataW-1:0] rem_d;
    logic [DataW:0]   diff;

    always_comb begin
      trial = {rem_q[s], low_q[s][DataW-1]};
      diff  = trial - {1'b0, den_q[s]};
      ge    = trial >= {1'b0, den_q[s]};
      rem_d = ge ? diff[DataW-1:0] : trial[DataW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_d;
        low_q[s+1]  <= {low_q[s][DataW-2:0], ge};
        den_q[s+1]  <= den_q[s];
        base_q[s+1] <= base_q[s];
        neg_q[s+1]  <= neg_q[s];
      end
    end
  end

  assign result_o = neg_q[Steps] ? base_q[Steps] - low_q[Steps]
                                 : base_q[Steps] + low_q[Steps];
endmodule
`default_nettype wire

[rtl/irregular_table_linear_interpolator.sv]
// top level: table storage, search, multiply and divider pipeline
// A word with cmd 0 writes one table entry and gives no result; a word with cmd 1
// interpolates aperture and cutoff at query_time. One word is accepted per cycle
// while the output is not stalled. A query passes the input register, search,
// table read, differences, products, the 32-stage divider (one quotient bit per
// stage) and the output register; a stall at the output holds the whole pipeline.
`default_nettype none
module irregular_table_linear_interpolator import itli_pkg::*; #(
  parameter int unsigned MAX_POINTS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [CountW-1:0]  cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic               cmd_i,
  input  wire logic [3:0]         entry_index_i,
  input  wire logic signed [31:0] entry_time_i,
  input  wire logic signed [31:0] entry_aperture_i,
  input  wire logic signed [31:0] entry_cutoff_i,
  input  wire logic signed [31:0] query_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [31:0]      aperture_out_o,
  output logic signed [31:0]      cutoff_out_o
);
  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = IW + 1;
  localparam int unsigned DivDepth = DataW;

  logic adv;
  logic [CountW-1:0] count_q;

  logic [DataW-1:0] time_q [MAX_POINTS];
  logic [DataW-1:0] ap_q   [MAX_POINTS];
  logic [DataW-1:0] co_q   [MAX_POINTS];

  // stage 0: input register
  logic s0_valid_q;
  logic s0_cmd_q;
  logic [3:0] s0_idx_q;
  logic [DataW-1:0] s0_time_q, s0_ap_q, s0_co_q, s0_query_q;

  // stage 1: search
  logic s1_valid_q;
  logic [IW-1:0] s1_lo_q, s1_hi_q;
  logic [DataW-1:0] s1_query_q;
  logic [IW-1:0] lo_d, hi_d, last_d;
  logic [CW+CountW-1:0] count_ext;

  // stage 2: table read
  logic s2_valid_q;
  logic [DataW-1:0] s2_query_q, s2_tlo_q, s2_thi_q, s2_alo_q, s2_ahi_q, s2_clo_q, s2_chi_q;

  // stage 3: differences
  logic s3_valid_q;
  logic [DataW-1:0] s3_dx_q, s3_den_q, s3_amag_q, s3_cmag_q, s3_abase_q, s3_cbase_q;
  logic s3_aneg_q, s3_cneg_q;
  logic [DataW-1:0] dx_d, den_raw, den_d, amag_d, cmag_d;
  logic [DataW:0] ady, cdy;

  // stage 4: products
  logic s4_valid_q;
  logic [ProdW-1:0] s4_aprod_q, s4_cprod_q;
  logic [DataW-1:0] s4_den_q, s4_abase_q, s4_cbase_q;
  logic s4_aneg_q, s4_cneg_q;

  logic [DivDepth-1:0] div_valid_q;
  logic [DataW-1:0] ap_res, co_res;
  logic out_valid_q;
  logic [DataW-1:0] ap_out_q, co_out_q;

  assign adv        = !out_valid_q || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= CountW'(1);
    end else if (cfg_we_i) begin
      count_q <= cfg_wdata_i;
    end
  end

  // points in use, clamped to 1..MAX_POINTS
  always_comb begin
    count_ext = (CW + CountW)'(count_q);
    if (count_ext == '0) begin
      last_d = '0;
    end else if (count_ext > (CW + CountW)'(MAX_POINTS)) begin
      last_d = IW'(MAX_POINTS - 1);
    end else begin
      last_d = IW'(count_ext - (CW + CountW)'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      s4_valid_q  <= 1'b0;
      div_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s0_valid_q  <= in_valid_i;
      s1_valid_q  <= s0_valid_q && (s0_cmd_q == CMD_QUERY);
      s2_valid_q  <= s1_valid_q;
      s3_valid_q  <= s2_valid_q;
      s4_valid_q  <= s3_valid_q;
      div_valid_q <= {div_valid_q[DivDepth-2:0], s4_valid_q};
      out_valid_q <= div_valid_q[DivDepth-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s0_cmd_q   <= cmd_i;
      s0_idx_q   <= entry_index_i;
      s0_time_q  <= entry_time_i;
      s0_ap_q    <= entry_aperture_i;
      s0_co_q    <= entry_cutoff_i;
      s0_query_q <= query_time_i;
    end
  end

  // table write lands as the word leaves stage 0
  always_ff @(posedge clk_i) begin
    if (adv && s0_valid_q && (s0_cmd_q == CMD_WRITE) &&
        ((CW + 4)'(s0_idx_q) < (CW + 4)'(MAX_POINTS))) begin
      time_q[IW'(s0_idx_q)] <= s0_time_q;
      ap_q[IW'(s0_idx_q)]   <= s0_ap_q;
      co_q[IW'(s0_idx_q)]   <= s0_co_q;
    end
  end

  itli_search #(
    .MAX_POINTS (MAX_POINTS),
    .IW         (IW)
  ) u_search (
    .times_i (time_q),
    .query_i (s0_query_q),
    .last_i  (last_d),
    .lo_o    (lo_d),
    .hi_o    (hi_d)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_lo_q    <= lo_d;
      s1_hi_q    <= hi_d;
      s1_query_q <= s0_query_q;
      s2_query_q <= s1_query_q;
      s2_tlo_q   <= time_q[s1_lo_q];
      s2_thi_q   <= time_q[s1_hi_q];
      s2_alo_q   <= ap_q[s1_lo_q];
      s2_ahi_q   <= ap_q[s1_hi_q];
      s2_clo_q   <= co_q[s1_lo_q];
      s2_chi_q   <= co_q[s1_hi_q];
    end
  end

  always_comb begin
    dx_d    = s2_query_q - s2_tlo_q;
    den_raw = s2_thi_q - s2_tlo_q;
    den_d   = (den_raw == '0) ? DataW'(1) : den_raw;
    ady     = {s2_ahi_q[DataW-1], s2_ahi_q} - {s2_alo_q[DataW-1], s2_alo_q};
    cdy     = {s2_chi_q[DataW-1], s2_chi_q} - {s2_clo_q[DataW-1], s2_clo_q};
    amag_d  = ady[DataW] ? DataW'(-ady) : ady[DataW-1:0];
    cmag_d  = cdy[DataW] ? DataW'(-cdy) : cdy[DataW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_dx_q    <= dx_d;
      s3_den_q   <= den_d;
      s3_amag_q  <= amag_d;
      s3_cmag_q  <= cmag_d;
      s3_aneg_q  <= ady[DataW];
      s3_cneg_q  <= cdy[DataW];
      s3_abase_q <= s2_alo_q;
      s3_cbase_q <= s2_clo_q;
      s4_aprod_q <= ProdW'(s3_dx_q) * ProdW'(s3_amag_q);
      s4_cprod_q <= ProdW'(s3_dx_q) * ProdW'(s3_cmag_q);
      s4_den_q   <= s3_den_q;
      s4_abase_q <= s3_abase_q;
      s4_cbase_q <= s3_cbase_q;
      s4_aneg_q  <= s3_aneg_q;
      s4_cneg_q  <= s3_cneg_q;
    end
  end

  itli_div u_div_ap (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (s4_aprod_q),
    .den_i      (s4_den_q),
    .base_i     (s4_abase_q),
    .neg_i      (s4_aneg_q),
    .result_o   (ap_res)
  );

  itli_div u_div_co (
    .clk_i      (clk_i),
    .en_i       (adv),
    .dividend_i (s4_cprod_q),
    .den_i      (s4_den_q),
    .base_i     (s4_cbase_q),
    .neg_i      (s4_cneg_q),
    .result_o   (co_res)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ap_out_q <= ap_res;
      co_out_q <= co_res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign aperture_out_o = ap_out_q;
  assign cutoff_out_o   = co_out_q;
endmodule
`default_nettype wire

[bench/itli_checker.sv]
// interpolation checker: tracks table and point count, predicts and compares results
module itli_checker import itli_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CountW-1:0]  cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               cmd_i,
  input  logic [3:0]         entry_index_i,
  input  logic signed [31:0] entry_time_i,
  input  logic signed [31:0] entry_aperture_i,
  input  logic signed [31:0] entry_cutoff_i,
  input  logic signed [31:0] query_time_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] aperture_out_i,
  input  logic signed [31:0] cutoff_out_i,
  output int                 fail_count_o,
  output int                 waiting_o
);
  typedef struct packed {
    logic signed [31:0] aperture;
    logic signed [31:0] cutoff;
  } interp_t;

  logic signed [31:0] bp_time [16];
  logic signed [31:0] bp_aperture [16];
  logic signed [31:0] bp_cutoff [16];
  logic [CountW-1:0]  point_count;
  interp_t            interp_q [$];

  function automatic logic signed [31:0] lerp(longint q, longint t1, longint t2,
                                              longint y1, longint y2);
    longint unsigned dx, den, mag, quo;
    longint dy;
    longint res;
    dx = longint'(q - t1);
    den = longint'(t2 - t1);
    dy = y2 - y1;
    mag = (dy < 0) ? longint'(-dy) : longint'(dy);
    quo = (dx * mag) / den;
    res = (dy < 0) ? y1 - longint'(quo) : y1 + longint'(quo);
    return res[31:0];
  endfunction

  function automatic interp_t interp_expected(logic signed [31:0] qt);
    interp_t r;
    int n, last, hi;
    longint q;
    q = qt;
    n = (point_count == 0) ? 1 : (point_count > 16) ? 16 : point_count;
    last = n - 1;
    if (q < longint'(bp_time[0])) begin
      r.aperture = bp_aperture[0];
      r.cutoff = bp_cutoff[0];
    end else if (q >= longint'(bp_time[last])) begin
      r.aperture = bp_aperture[last];
      r.cutoff = bp_cutoff[last];
    end else begin
      hi = last;
      for (int i = last - 1; i >= 1; i--)
        if (longint'(bp_time[i]) > q) hi = i;
      r.aperture = lerp(q, bp_time[hi-1], bp_time[hi], bp_aperture[hi-1], bp_aperture[hi]);
      r.cutoff = lerp(q, bp_time[hi-1], bp_time[hi], bp_cutoff[hi-1], bp_cutoff[hi]);
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    interp_t want;
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) begin
        bp_time[i] = '0;
        bp_aperture[i] = '0;
        bp_cutoff[i] = '0;
      end
      point_count = 5'd1;
      interp_q.delete();
      fail_count_o <= 0;
      waiting_o <= 0;
    end else begin
      if (cfg_we_i) point_count = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (interp_q.size() == 0) begin
          $display("%0t: unexpected result ap=%h co=%h", $time, aperture_out_i, cutoff_out_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = interp_q.pop_front();
          if (want.aperture !== aperture_out_i || want.cutoff !== cutoff_out_i) begin
            $display("%0t: mismatch expected ap=%h co=%h actual ap=%h co=%h", $time,
                     want.aperture, want.cutoff, aperture_out_i, cutoff_out_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (cmd_e'(cmd_i) == CMD_WRITE) begin
          bp_time[entry_index_i] = entry_time_i;
          bp_aperture[entry_index_i] = entry_aperture_i;
          bp_cutoff[entry_index_i] = entry_cutoff_i;
        end else begin
          interp_q.push_back(interp_expected(query_time_i));
        end
      end
      waiting_o <= interp_q.size();
    end
  end
endmodule

[bench/tb_irregular_table_linear_interpolator.sv]
// testbench top: table loads, queries, point count sweeps and verdict
module tb_irregular_table_linear_interpolator import itli_pkg::*;;
  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CountW-1:0]  cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = 1'b0;
  logic [3:0]         entry_index = '0;
  logic signed [31:0] entry_time = '0;
  logic signed [31:0] entry_aperture = '0;
  logic signed [31:0] entry_cutoff = '0;
  logic signed [31:0] query_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] aperture_out;
  logic signed [31:0] cutoff_out;
  int                 fail_count;
  int                 waiting;
  bit                 calm = 1'b0;
  int                 word_count = 0;
  logic signed [31:0] tbl_time [16];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  irregular_table_linear_interpolator dut (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .cmd_i(cmd),
    .entry_index_i(entry_index), .entry_time_i(entry_time),
    .entry_aperture_i(entry_aperture), .entry_cutoff_i(entry_cutoff),
    .query_time_i(query_time), .out_valid_o(out_valid), .out_ready_i(out_ready),
    .aperture_out_o(aperture_out), .cutoff_out_o(cutoff_out)
  );

  itli_checker chk (
    .clk_i, .rst_ni, .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .cmd_i(cmd),
    .entry_index_i(entry_index), .entry_time_i(entry_time),
    .entry_aperture_i(entry_aperture), .entry_cutoff_i(entry_cutoff),
    .query_time_i(query_time), .out_valid_i(out_valid), .out_ready_i(out_ready),
    .aperture_out_i(aperture_out), .cutoff_out_i(cutoff_out),
    .fail_count_o(fail_count), .waiting_o(waiting)
  );

  function automatic logic signed [31:0] rnd32();
    return $urandom();
  endfunction

  task automatic send_word(cmd_e c, logic [3:0] idx, logic signed [31:0] t,
                           logic signed [31:0] ap, logic signed [31:0] co,
                           logic signed [31:0] q);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cmd <= c;
    entry_index <= idx;
    entry_time <= t;
    entry_aperture <= ap;
    entry_cutoff <= co;
    query_time <= q;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
    word_count++;
    if (c == CMD_WRITE) tbl_time[idx] = t;
  endtask

  task automatic write_entry(logic [3:0] idx, logic signed [31:0] t,
                             logic signed [31:0] ap, logic signed [31:0] co);
    send_word(CMD_WRITE, idx, t, ap, co, rnd32());
  endtask

  task automatic query(logic signed [31:0] q);
    send_word(CMD_QUERY, 4'($urandom_range(0, 15)), rnd32(), rnd32(), rnd32(), q);
  endtask

  task automatic set_points(logic [CountW-1:0] n);
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= n;
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      default: return rnd32();
    endcase
  endfunction

  task automatic load_table();
    logic signed [31:0] t [$];
    int mode, step;
    mode = $urandom_range(0, 4);
    t.delete();
    case (mode)
      0, 1: begin
        for (int i = 0; i < 16; i++) t.push_back(rnd32());
        t.sort();
      end
      2: begin
        t.push_back(rnd32() >>> 4);
        for (int i = 1; i < 16; i++) begin
          step = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5000);
          t.push_back(t[i-1] + step);
        end
      end
      3: begin
        for (int i = 0; i < 16; i++) t.push_back(rnd32());
      end
      default: begin
        for (int i = 0; i < 16; i++) t.push_back(rnd32());
        t.sort();
        t[0] = 32'sh80000000;
        t[15] = 32'sh7fffffff;
      end
    endcase
    for (int i = 0; i < 16; i++) write_entry(4'(i), t[i], pick_value(), pick_value());
  endtask

  function automatic logic signed [31:0] aim_query();
    int k;
    longint lo, hi;
    k = $urandom_range(0, 14);
    lo = tbl_time[k];
    hi = tbl_time[k+1];
    case ($urandom_range(0, 7))
      0: return rnd32();
      1: return tbl_time[$urandom_range(0, 15)];
      2: return tbl_time[k] - 1;
      3: return tbl_time[k] + 1;
      4: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: begin
        if (hi > lo) return 32'(lo + longint'({$urandom(), $urandom()} % (hi - lo)));
        return tbl_time[k];
      end
    endcase
  endfunction

  initial begin
    logic [CountW-1:0] counts [6] = '{5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd31};
    int phase;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    set_points(5'd16);
    write_entry(4'd0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
    for (int i = 1; i < 15; i++)
      write_entry(4'(i), 32'sh80000000 + i * 32'sh10000000, pick_value(), pick_value());
    write_entry(4'd15, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
    query(32'sh80000000);
    query(32'sh7fffffff);
    query(32'sh7ffffffe);
    query(32'sh90000000);
    query(32'sh98000000);
    query(32'sh0);
    query(32'shffffffff);
    query(32'sh70000001);
    set_points(5'd1);
    query(32'sh0);
    phase = 0;
    while (word_count < 1050) begin
      if (phase < 6) set_points(counts[phase]);
      else set_points(5'($urandom_range(0, 31)));
      calm = (phase % 4 == 3);
      load_table();
      repeat (60) begin
        if ($urandom_range(0, 9) == 0)
          write_entry(4'($urandom_range(0, 15)), aim_query(), pick_value(), pick_value());
        else
          query(aim_query());
      end
      phase++;
    end
    in_valid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (60) @(negedge clk_i);
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int stall;
    int seen;
    seen = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (seen == 30) stall = 300;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      seen++;
      @(negedge clk_i);
    end
  end

  initial begin
    #3_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule
